[src/att_pkg.sv]
// ----------------------------------------------------------------------------
// Argmin tournament tree package
// Shared field widths and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package att_pkg;

    localparam int IDX_BITS   = 6;
    localparam int VAL_BITS   = 32;
    localparam int TDATA_BITS = 40;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic issue;
        logic out_load;
    } att_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic issue_last;
    } att_status_t;

endpackage

[src/att_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/att_ctrl.sv]
// ----------------------------------------------------------------------------
// Argmin tournament tree controller
// Sequences the clearing pass, the walk from leaf to root and the hand-over
// of each result to the output register.
// ----------------------------------------------------------------------------
module att_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  att_pkg::att_status_t status,
    output att_pkg::att_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_range ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[src/att_datapath.sv]
// ----------------------------------------------------------------------------
// Argmin tournament tree datapath
// Holds the value store and the winner store, walks one tree level per cycle
// with a read stage and a compare stage, and keeps the root winner.
// ----------------------------------------------------------------------------
module att_datapath #(
    parameter int LEAF_COUNT = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  att_pkg::att_cmd_t                    cmd,
    output att_pkg::att_status_t                 status,
    input  logic [att_pkg::IDX_BITS-1:0]         in_index,
    input  logic signed [att_pkg::VAL_BITS-1:0]  in_value,
    output logic [att_pkg::IDX_BITS-1:0]         out_index,
    output logic signed [att_pkg::VAL_BITS-1:0]  out_value
);

    localparam int IW    = $clog2(LEAF_COUNT);
    localparam int NW    = $clog2(2 * LEAF_COUNT - 1);
    localparam int WAW   = (LEAF_COUNT - 1 > 1) ? $clog2(LEAF_COUNT - 1) : 1;
    localparam int EW    = ((IW > att_pkg::IDX_BITS) ? IW : att_pkg::IDX_BITS) + 1;
    localparam int LW    = IW + NW + 1;
    localparam int VW    = att_pkg::VAL_BITS;
    localparam int WW    = IW + VW;
    localparam int INNER = LEAF_COUNT - 1;

    logic [IW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]         node_reg, node_next;
    logic                  p1_valid_reg, p1_valid_next;
    logic                  p1_left_reg, p1_leaf_reg;
    logic [IW-1:0]         p1_leafidx_reg;
    logic [WAW-1:0]        p1_parent_reg;
    logic [IW-1:0]         c_idx_reg, c_idx_next;
    logic signed [VW-1:0]  c_val_reg, c_val_next;
    logic [IW-1:0]         root_idx_reg, root_idx_next;
    logic signed [VW-1:0]  root_val_reg, root_val_next;
    logic [att_pkg::IDX_BITS-1:0] out_index_reg;
    logic signed [VW-1:0]  out_value_reg;

    logic [IW-1:0]         idx_int;
    logic [NW-1:0]         sib, parent;
    logic                  sib_leaf;
    logic [NW-1:0]         sib_leafnode;
    logic [LW-1:0]         lm_base, lm_node;
    logic [IW-1:0]         lm_leaf;
    logic [EW-1:0]         root_ext;

    logic                  v_we, w_we;
    logic [IW-1:0]         v_waddr, v_raddr;
    logic [VW-1:0]         v_wdata, v_rdata;
    logic [WAW-1:0]        w_waddr, w_raddr;
    logic [WW-1:0]         w_wdata, w_rdata;

    logic [IW-1:0]         sib_idx, win_idx;
    logic signed [VW-1:0]  sib_val, win_val;
    logic                  take_sib;

    assign idx_int             = IW'(in_index);
    assign status.in_range     = EW'(in_index) < EW'(LEAF_COUNT);
    assign status.clear_last   = (clr_cnt_reg == IW'(LEAF_COUNT - 1));
    assign status.issue_last   = (parent == '0);

    assign sib          = node_reg[0] ? (node_reg + NW'(1)) : (node_reg - NW'(1));
    assign parent       = (node_reg - NW'(1)) >> 1;
    assign sib_leaf     = (sib >= NW'(INNER));
    assign sib_leafnode = sib - NW'(INNER);

    always_comb begin
        lm_base = LW'(clr_cnt_reg) + LW'(1);
        lm_node = lm_base << IW;
        for (int j = IW; j >= 0; j--) begin
            if ((lm_base << j) >= LW'(LEAF_COUNT)) begin
                lm_node = lm_base << j;
            end
        end
        lm_leaf = IW'(lm_node - LW'(LEAF_COUNT));
    end

    always_comb begin
        sib_idx  = p1_leaf_reg ? p1_leafidx_reg : w_rdata[WW-1:VW];
        sib_val  = p1_leaf_reg ? $signed(v_rdata) : $signed(w_rdata[VW-1:0]);
        take_sib = p1_left_reg ? (c_val_reg > sib_val) : !(c_val_reg < sib_val);
        win_idx  = take_sib ? sib_idx : c_idx_reg;
        win_val  = take_sib ? sib_val : c_val_reg;
    end

    always_comb begin
        v_we    = 1'b0;
        v_waddr = idx_int;
        v_wdata = in_value;
        if (cmd.clear_en) begin
            v_we    = 1'b1;
            v_waddr = clr_cnt_reg;
            v_wdata = '0;
        end else if (cmd.load && status.in_range) begin
            v_we = 1'b1;
        end
        v_raddr = sib_leaf ? IW'(sib_leafnode) : '0;

        w_we    = 1'b0;
        w_waddr = p1_parent_reg;
        w_wdata = {win_idx, win_val};
        if (cmd.clear_en) begin
            w_we    = (EW'(clr_cnt_reg) < EW'(INNER));
            w_waddr = WAW'(clr_cnt_reg);
            w_wdata = {lm_leaf, {VW{1'b0}}};
        end else if (p1_valid_reg) begin
            w_we = 1'b1;
        end
        w_raddr = sib_leaf ? '0 : WAW'(sib);
    end

    att_ram #(
        .WIDTH (VW),
        .DEPTH (LEAF_COUNT)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    att_ram #(
        .WIDTH (WW),
        .DEPTH (INNER)
    ) u_winner_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    always_comb begin
        clr_cnt_next  = cmd.clear_en ? (clr_cnt_reg + IW'(1)) : clr_cnt_reg;
        node_next     = node_reg;
        c_idx_next    = c_idx_reg;
        c_val_next    = c_val_reg;
        root_idx_next = root_idx_reg;
        root_val_next = root_val_reg;
        p1_valid_next = cmd.issue;
        if (cmd.load) begin
            node_next  = NW'(INNER) + NW'(idx_int);
            c_idx_next = idx_int;
            c_val_next = in_value;
        end else if (cmd.issue) begin
            node_next = parent;
        end
        if (p1_valid_reg) begin
            c_idx_next = win_idx;
            c_val_next = win_val;
            if (p1_parent_reg == '0) begin
                root_idx_next = win_idx;
                root_val_next = win_val;
            end
        end
        if (cmd.clear_en && (clr_cnt_reg == '0)) begin
            root_idx_next = lm_leaf;
            root_val_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            root_idx_reg <= '0;
            root_val_reg <= '0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            p1_valid_reg <= p1_valid_next;
            root_idx_reg <= root_idx_next;
            root_val_reg <= root_val_next;
        end
    end

    assign root_ext = EW'(root_idx_reg);

    always_ff @(posedge aclk) begin
        node_reg  <= node_next;
        c_idx_reg <= c_idx_next;
        c_val_reg <= c_val_next;
        if (cmd.issue) begin
            p1_left_reg    <= node_reg[0];
            p1_leaf_reg    <= sib_leaf;
            p1_leafidx_reg <= IW'(sib_leafnode);
            p1_parent_reg  <= WAW'(parent);
        end
        if (cmd.out_load) begin
            out_index_reg <= root_ext[att_pkg::IDX_BITS-1:0];
            out_value_reg <= root_val_reg;
        end
    end

    assign out_index = out_index_reg;
    assign out_value = out_value_reg;

endmodule

[src/argmin_tournament_tree.sv]
// ----------------------------------------------------------------------------
// Argmin tournament tree
// Keeps LEAF_COUNT signed values and a tournament tree of winner indices.
//
// Each request on the s_ channel overwrites one stored value and updates the
// tree nodes on the path from that leaf to the root. Each request gives one
// result on the m_ channel: the index and value of the smallest stored value,
// the leftmost one when several are equal. An index beyond the stored range
// writes nothing and returns the current minimum.
// An in-range request walks the tree one level per cycle from its leaf to the
// root, then takes a last compare and loads the output register; a new request
// is not taken before the previous one is through.
// The next request is accepted once the previous result has been loaded into
// the output register, so a stalled receiver holds the block after one
// further request has been worked through.
// After reset the block runs a clearing pass through both RAMs, with s_tready
// low, and then holds all values at zero.
// ----------------------------------------------------------------------------
module argmin_tournament_tree #(
    parameter int LEAF_COUNT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [att_pkg::TDATA_BITS-1:0]   s_tdata,   // entry_index, new_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [att_pkg::TDATA_BITS-1:0]   m_tdata    // min_index, min_value
);

    localparam int IB = att_pkg::IDX_BITS;
    localparam int VB = att_pkg::VAL_BITS;

    att_pkg::att_cmd_t    cmd;
    att_pkg::att_status_t status;
    logic [IB-1:0]        min_index;
    logic signed [VB-1:0] min_value;

    att_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    att_datapath #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_index  (s_tdata[IB-1:0]),
        .in_value  ($signed(s_tdata[IB+VB-1:IB])),
        .out_index (min_index),
        .out_value (min_value)
    );

    assign m_tdata = {{(att_pkg::TDATA_BITS - IB - VB){1'b0}}, min_value, min_index};

endmodule

[bench/argmin_tournament_tree_tb.sv]
// ----------------------------------------------------------------------------
// Argmin tournament tree testbench
// Drives update requests into argmin_tournament_tree and checks every result
// against a leftmost-minimum prediction kept over a private copy of the
// stored values. Directed requests cover the cleared state, the value
// extremes and ties; random requests then churn the minimum under random
// idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module argmin_tournament_tree_tb;

    localparam int IDX_BITS   = att_pkg::IDX_BITS;
    localparam int VAL_BITS   = att_pkg::VAL_BITS;
    localparam int TDATA_BITS = att_pkg::TDATA_BITS;

    localparam int LEAVES = 64;
    localparam int PAD_BITS = TDATA_BITS - IDX_BITS - VAL_BITS;

    typedef struct packed {
        logic [IDX_BITS-1:0]        index;
        logic signed [VAL_BITS-1:0] value;
    } minimum_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    logic signed [VAL_BITS-1:0] held_value [LEAVES] = '{default: '0};
    minimum_t                   expected_minima [$];
    int                         fail_count = 0;
    int                         result_count = 0;
    bit                         tx_idle_on = 1'b0;
    bit                         rx_idle_on = 1'b0;
    int                         hold_left = 0;

    argmin_tournament_tree #(
        .LEAF_COUNT(LEAVES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic minimum_t leftmost_minimum();
        minimum_t                   best;
        logic signed [VAL_BITS-1:0] best_value;
        best.index = '0;
        best_value = held_value[0];
        for (int i = 1; i < LEAVES; i++) begin
            if (held_value[i] < best_value) begin
                best.index = IDX_BITS'(i);
                best_value = held_value[i];
            end
        end
        best.value = best_value;
        return best;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic send_update(input logic [IDX_BITS-1:0] idx,
                               input logic signed [VAL_BITS-1:0] val);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_BITS{1'b0}}, val, idx};
        do @(posedge aclk); while (!s_tready);
        held_value[idx] = val;
        expected_minima.push_back(leftmost_minimum());
    endtask

    // Receiver: a fresh stall is drawn after each accepted result.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                stall_left = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        minimum_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_minima.size() == 0) begin
                report_mismatch($sformatf("result %0d with none expected, tdata %h",
                                          result_count, m_tdata));
            end else begin
                want = expected_minima.pop_front();
                if (m_tdata[IDX_BITS-1:0] !== want.index)
                    report_mismatch($sformatf("result %0d min_index %0d, expected %0d",
                                              result_count, m_tdata[IDX_BITS-1:0],
                                              want.index));
                if (m_tdata[IDX_BITS +: VAL_BITS] !== want.value)
                    report_mismatch($sformatf("result %0d min_value %0d, expected %0d",
                                              result_count,
                                              $signed(m_tdata[IDX_BITS +: VAL_BITS]),
                                              want.value));
            end
        end
    end

    task automatic test_cleared_state();
        send_update(6'd63, 32'sd0);
        send_update(6'd0, 32'sd1);
        send_update(6'd0, 32'sd0);
    endtask

    task automatic test_value_extremes();
        send_update(6'd0, 32'sh7FFF_FFFF);
        send_update(6'd63, 32'sh8000_0000);
        send_update(6'd0, 32'sh8000_0000);
        send_update(6'd0, 32'sh7FFF_FFFF);
        send_update(6'd63, -32'sd1);
        send_update(6'd42, 32'sh5555_5555);
        send_update(6'd21, 32'shAAAA_AAAA);
        send_update(6'd21, 32'sd0);
        send_update(6'd63, 32'sd0);
        send_update(6'd0, 32'sd0);
        send_update(6'd42, 32'sd0);
    endtask

    task automatic test_ties();
        send_update(6'd40, -32'sd5);
        send_update(6'd20, -32'sd5);
        send_update(6'd50, -32'sd5);
        send_update(6'd20, 32'sd0);
        send_update(6'd40, 32'sd0);
        send_update(6'd3, -32'sd9);
        send_update(6'd2, -32'sd9);
        send_update(6'd32, -32'sd9);
        send_update(6'd31, -32'sd9);
        send_update(6'd2, 32'sd0);
    endtask

    task automatic test_random_updates(input int count, input bit tx_idle, input bit rx_idle);
        int                         pick;
        minimum_t                   lowest;
        logic [IDX_BITS-1:0]        idx;
        logic signed [VAL_BITS-1:0] val;
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        repeat (count) begin
            pick   = $urandom_range(0, 99);
            lowest = leftmost_minimum();
            idx    = IDX_BITS'($urandom_range(0, LEAVES - 1));
            if (pick < 40) begin
                val = $urandom_range(0, 15) - 8;
            end else if (pick < 60) begin
                idx = lowest.index;
                val = $urandom;
            end else if (pick < 75) begin
                val = lowest.value - 1;
            end else if (pick < 80) begin
                val = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else begin
                val = $urandom;
            end
            send_update(idx, val);
        end
    endtask

    task automatic test_receiver_hold_off();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_left  = 300;
        repeat (30) send_update(IDX_BITS'($urandom_range(0, LEAVES - 1)), $urandom);
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_cleared_state();
        test_value_extremes();
        test_ties();
        test_random_updates(350, 1'b1, 1'b1);
        test_random_updates(350, 1'b0, 1'b0);
        test_receiver_hold_off();
        test_random_updates(350, 1'b1, 1'b0);
        test_random_updates(350, 1'b0, 1'b1);

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_minima.size() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_minima.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_minima.size()));
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("argmin_tournament_tree regression: pass");
        end else begin
            $display("argmin_tournament_tree regression: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("argmin_tournament_tree regression: fail");
        $finish;
    end

endmodule
